[design/work_stealing_task_deque_unit_assert.svh]
// Assertion macros shared by the deque checker.
`ifndef WORK_STEALING_TASK_DEQUE_UNIT_ASSERT_SVH
`define WORK_STEALING_TASK_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WSTD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WSTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/wstd_pkg.sv]
`default_nettype none

package wstd_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_STEAL = 2'd2,
      REQ_RESET = 2'd3
   } wstd_req_type;

   // Response status codes
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_REFUSED = 2'd3
   } wstd_status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } wstd_state_type;

endpackage

`default_nettype wire

[design/work_stealing_task_deque_unit.sv]
// Response: presented in the cycle after its request is accepted.
// Requests: none is taken before the last response is; the response register
//   is single and the store's registered read port serves one read per request.
// Reset: synchronous, active high; bottom and top indices go to zero, the
//   task store keeps whatever it holds (no clearing pass).
`default_nettype none

module work_stealing_task_deque_unit #(
   parameter int DEPTH     = 256,
   parameter int TASK_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((TASK_BITS + 7) / 8) * 8-1:0] req_tdata,  // [TASK_BITS-1:0] task_in
   input  wire logic [1:0]                          req_tuser,  // [1:0] req_type
   // response channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [((TASK_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // [TASK_BITS-1:0] task_out
   output logic      [2:0]                          rsp_tuser   // [0] task_valid, [2:1] status
);

   localparam int TDATA_BITS = ((TASK_BITS + 7) / 8) * 8;

   logic                 load;
   logic [TASK_BITS-1:0] task_out;
   logic                 task_valid;
   logic [1:0]           status;

   // Controller: IDLE takes a request, RESP holds the response until taken.
   wstd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .load       (load)
   );

   // Datapath: indices, slot RAM, response fields.
   wstd_dp #(
      .DEPTH     (DEPTH),
      .TASK_BITS (TASK_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .req_type   (req_tuser),
      .task_in    (req_tdata[TASK_BITS-1:0]),
      .task_out   (task_out),
      .task_valid (task_valid),
      .status     (status)
   );

   // pad bits above the task are zero
   assign rsp_tdata = TDATA_BITS'(task_out);
   assign rsp_tuser = {status, task_valid};

endmodule

`default_nettype wire

[design/wstd_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module wstd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/wstd_ctrl.sv]
`default_nettype none

// Handshake sequencer: take one request, hold its response until taken.
module wstd_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output logic      load
);

   wstd_pkg::wstd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wstd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wstd_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = wstd_pkg::ST_RESP;
         end
         wstd_pkg::ST_RESP: begin
            if (rsp_tready) state_in = wstd_pkg::ST_IDLE;
         end
         default: state_in = wstd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         wstd_pkg::ST_IDLE: begin
            // no request is taken while reset is held
            req_tready = !reset;
            load       = req_tvalid && !reset;
         end
         wstd_pkg::ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/wstd_dp.sv]
`default_nettype none

// Index registers, slot store and response registers.
module wstd_dp #(
   parameter int DEPTH     = 256,
   parameter int TASK_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic [1:0]           req_type,
   input  wire logic [TASK_BITS-1:0] task_in,
   output logic      [TASK_BITS-1:0] task_out,
   output logic                      task_valid,
   output logic      [1:0]           status
);

   localparam int IDX_BITS  = $clog2(DEPTH + 1);
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam logic [IDX_BITS-1:0] FULL_MARK = IDX_BITS'(DEPTH);
   localparam logic [IDX_BITS-1:0] ONE       = IDX_BITS'(1);

   logic [IDX_BITS-1:0] bottom_ff, bottom_in;
   logic [IDX_BITS-1:0] top_ff, top_in;
   logic                valid_ff, valid_in;
   wstd_pkg::wstd_status_type status_ff, status_in;

   logic [IDX_BITS-1:0]  bottom_dec;
   logic                 wr_en, rd_en;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [TASK_BITS-1:0] rd_data;

   assign bottom_dec = bottom_ff - ONE;

   always_comb begin
      bottom_in = bottom_ff;
      top_in    = top_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = top_ff[ADDR_BITS-1:0];
      if (load) begin
         valid_in  = 1'b0;
         status_in = wstd_pkg::STAT_OK;
         unique case (wstd_pkg::wstd_req_type'(req_type))
            wstd_pkg::REQ_PUSH: begin
               if (bottom_ff >= FULL_MARK) begin
                  status_in = wstd_pkg::STAT_FULL;
               end else begin
                  wr_en     = 1'b1;
                  bottom_in = bottom_ff + ONE;
               end
            end
            wstd_pkg::REQ_POP: begin
               if (bottom_ff <= top_ff) begin
                  bottom_in = top_ff;
                  status_in = wstd_pkg::STAT_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = bottom_dec[ADDR_BITS-1:0];
                  valid_in = 1'b1;
                  if (bottom_dec > top_ff) begin
                     bottom_in = bottom_dec;
                  end else begin
                     // last task: both indices step past it
                     top_in    = top_ff + ONE;
                     bottom_in = top_ff + ONE;
                  end
               end
            end
            wstd_pkg::REQ_STEAL: begin
               if (top_ff >= bottom_ff) begin
                  status_in = wstd_pkg::STAT_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  valid_in = 1'b1;
                  top_in   = top_ff + ONE;
               end
            end
            wstd_pkg::REQ_RESET: begin
               if (bottom_ff == top_ff) begin
                  bottom_in = '0;
                  top_in    = '0;
               end else begin
                  status_in = wstd_pkg::STAT_REFUSED;
               end
            end
            default: status_in = wstd_pkg::STAT_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bottom_ff <= '0;
         top_ff    <= '0;
      end else begin
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
      valid_ff  <= valid_in;
      status_ff <= status_in;
   end

   wstd_ram #(
      .WIDTH (TASK_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bottom_ff[ADDR_BITS-1:0]),
      .wr_data (task_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read data holds until the next accepted read
   assign task_out   = valid_ff ? rd_data : '0;
   assign task_valid = valid_ff;
   assign status     = status_ff;

endmodule

`default_nettype wire

[design/wstd_checker.sv]
`default_nettype none

`include "work_stealing_task_deque_unit_assert.svh"

// Port-level checks for the deque.
module wstd_checker #(
   parameter int TASK_BITS = 16
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((TASK_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   input wire logic [2:0]                          rsp_tuser
);

   `WSTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   `WSTD_ASSERT_IMPL(a_no_task_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata == '0, "task_out nonzero without task_valid")

   `WSTD_ASSERT_IMPL(a_task_ok, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tuser[2:1] == wstd_pkg::STAT_OK, "task returned with non-ok status")

   `WSTD_ASSERT_NEXT(a_accept_resp, clock, reset, req_tvalid && req_tready,
      rsp_tvalid && !req_tready, "no response after accepted request")

endmodule

bind work_stealing_task_deque_unit wstd_checker #(.TASK_BITS(TASK_BITS)) u_checker (.*);

`default_nettype wire
